// ===== rtl/core/tel_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tel_pkg: shared types and constants of the text escape line numberer
// Holds character codes, register indexes, the command beat passed from the
// front end to the back end, and the byte rendering function.
// ----------------------------------------------------------------------------
package tel_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_NUMBER_MODE = 3'd0;
    localparam logic [2:0] REG_MARK_ENDS   = 3'd1;
    localparam logic [2:0] REG_CARET_TABS  = 3'd2;
    localparam logic [2:0] REG_CARET_CTRL  = 3'd3;
    localparam logic [2:0] REG_FOLD_BLANKS = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 2;

    // Numbering modes; the unused code acts like non-blank numbering
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ALL  = 2'd1;

    // Number field layout
    localparam logic [3:0] NUM_WIDTH   = 4'd6;
    localparam int         SHOW_DIGITS = 10;
    localparam logic [3:0] SHOW_MAX    = 4'd10;

    // Depth of the command queue, a power of two
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    localparam logic [6:0] LOW_DEL      = 7'h7F;
    localparam logic [6:0] CTRL_LIMIT   = 7'd32;
    localparam logic [7:0] CARET_OFFSET = 8'd64;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       mark_ends;
        logic       caret_tabs;
        logic       caret_ctrl;
        logic       fold_blanks;
    } cfg_t;

    // Up to four text bytes, byte 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } body_t;

    // One command: an optional line number followed by the body bytes
    typedef struct packed {
        logic                        has_num;
        logic [3:0]                  sig;
        logic [SHOW_DIGITS-1:0][3:0] digits;
        body_t                       body;
    } cmd_t;

    function automatic body_t low_caret(input logic [6:0] l);
        body_t r;
        r = '0;
        if (l < CTRL_LIMIT)
        begin
            r.b[0] = CH_CARET;
            r.b[1] = {1'b0, l} + CARET_OFFSET;
            r.len  = 3'd2;
        end
        else if (l == LOW_DEL)
        begin
            r.b[0] = CH_CARET;
            r.b[1] = CH_QUEST;
            r.len  = 3'd2;
        end
        else
        begin
            r.b[0] = {1'b0, l};
            r.len  = 3'd1;
        end
        return r;
    endfunction

    function automatic body_t render(input logic [7:0] c, input logic caret_tabs,
                                     input logic caret_ctrl);
        body_t r;
        body_t lc;
        r      = '0;
        r.b[0] = c;
        r.len  = 3'd1;
        lc     = low_caret(c[6:0]);
        if (caret_tabs && c == CH_TAB)
        begin
            r.b[0] = CH_CARET;
            r.b[1] = CH_I;
            r.len  = 3'd2;
        end
        else if (caret_ctrl && c != CH_TAB && c != CH_LF)
        begin
            if (c[7])
            begin
                r.b[0] = CH_M;
                r.b[1] = CH_DASH;
                r.b[2] = lc.b[0];
                r.b[3] = lc.b[1];
                r.len  = lc.len + 3'd2;
            end
            else
            begin
                r = lc;
            end
        end
        return r;
    endfunction

    function automatic body_t line_end(input logic mark_ends);
        body_t r;
        r = '0;
        if (mark_ends)
        begin
            r.b[0] = CH_DOLLAR;
            r.b[1] = CH_LF;
            r.len  = 3'd2;
        end
        else
        begin
            r.b[0] = CH_LF;
            r.len  = 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/tel_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tel_front: input classifier
// Accepts one byte or end mark per cycle while the queue has room, tracks line
// and blank-run state, advances the BCD line count and builds one output command.
// ----------------------------------------------------------------------------
module tel_front
    import tel_pkg::*;
#(
    parameter int COUNT_DIGITS = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_op,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    localparam int SIG_W = $clog2(COUNT_DIGITS + 1);

    logic                         als_reg, als_next;
    logic [1:0]                   blank_run_reg, blank_run_next;
    logic [COUNT_DIGITS-1:0][3:0] cnt_reg, cnt_next, cnt_inc;
    logic [COUNT_DIGITS-1:0]      nine, carry, low_mask;
    logic                         all_nines;
    logic                         do_count;
    logic                         accept;
    logic [SIG_W-1:0]             sig_raw;
    logic [SHOW_DIGITS-1:0][3:0]  dig_show;
    body_t                        body;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Saturating BCD increment; carries are formed per digit from the nine flags
    always_comb
    begin
        low_mask = '0;
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            nine[i] = (cnt_reg[i] == 4'd9);
        end
        all_nines = &nine;
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            low_mask = (COUNT_DIGITS'(1) << i) - COUNT_DIGITS'(1);
            carry[i] = ((nine & low_mask) == low_mask);
            if (all_nines || !carry[i])
                cnt_inc[i] = cnt_reg[i];
            else if (nine[i])
                cnt_inc[i] = 4'd0;
            else
                cnt_inc[i] = cnt_reg[i] + 4'd1;
        end
    end

    always_comb
    begin
        sig_raw = SIG_W'(1);
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            if (cnt_inc[i] != 4'd0)
                sig_raw = SIG_W'(i + 1);
        end
    end

    for (genvar k = 0; k < SHOW_DIGITS; k++)
    begin : g_show
        if (k < COUNT_DIGITS)
        begin : g_dig
            assign dig_show[k] = cnt_inc[k];
        end
        else
        begin : g_pad
            assign dig_show[k] = 4'd0;
        end
    end

    // Classify the item
    always_comb
    begin
        als_next       = als_reg;
        blank_run_next = blank_run_reg;
        do_count       = 1'b0;
        body           = '0;
        if (in_op)
        begin
            if (!als_reg)
                body = line_end(cfg.mark_ends);
            als_next       = 1'b1;
            blank_run_next = 2'd0;
        end
        else if (als_reg)
        begin
            if (in_byte == CH_LF)
            begin
                if (cfg.fold_blanks)
                    blank_run_next = (blank_run_reg == 2'd2) ? 2'd2 : blank_run_reg + 2'd1;
                else
                    blank_run_next = 2'd0;
                if (!(cfg.fold_blanks && blank_run_next > 2'd1))
                begin
                    do_count = (cfg.number_mode == MODE_ALL);
                    body     = line_end(cfg.mark_ends);
                end
            end
            else
            begin
                blank_run_next = 2'd0;
                do_count       = (cfg.number_mode != MODE_NONE);
                body           = render(in_byte, cfg.caret_tabs, cfg.caret_ctrl);
                als_next       = 1'b0;
            end
        end
        else
        begin
            if (in_byte == CH_LF)
            begin
                body     = line_end(cfg.mark_ends);
                als_next = 1'b1;
            end
            else
            begin
                body = render(in_byte, cfg.caret_tabs, cfg.caret_ctrl);
            end
        end
    end

    assign cnt_next = do_count ? cnt_inc : cnt_reg;

    always_comb
    begin
        q_cmd.has_num = do_count;
        q_cmd.sig     = (sig_raw > SIG_W'(SHOW_MAX)) ? SHOW_MAX : 4'(sig_raw);
        q_cmd.digits  = dig_show;
        q_cmd.body    = body;
    end

    // Drop items that print nothing
    assign q_push = accept && (body.len != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            als_reg       <= 1'b1;
            blank_run_reg <= 2'd0;
            cnt_reg       <= '0;
        end
        else if (accept)
        begin
            als_reg       <= als_next;
            blank_run_reg <= blank_run_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/tel_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tel_queue: command queue
// Small register FIFO that lets the classifier and the serializer stall
// independently of each other.
// ----------------------------------------------------------------------------
module tel_queue
    import tel_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/core/tel_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tel_back: output serializer
// Walks the head command one byte per beat: padded line number, space,
// then the body bytes, and flags the final beat of each command.
// ----------------------------------------------------------------------------
module tel_back
    import tel_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg, data_next;
    logic       m_tlast_reg;
    logic [3:0] pos_reg;
    logic [3:0] width, num_len, total, dpos, bidx;
    logic       is_last, load;

    assign load = !m_tvalid_reg || m_tready;

    always_comb
    begin
        width   = (head.sig > NUM_WIDTH) ? head.sig : NUM_WIDTH;
        num_len = head.has_num ? width + 4'd1 : 4'd0;
        total   = num_len + {1'b0, head.body.len};
        is_last = (pos_reg == total - 4'd1);
        dpos    = width - 4'd1 - pos_reg;
        bidx    = pos_reg - num_len;
        if (pos_reg < num_len)
        begin
            if (pos_reg == num_len - 4'd1 || dpos >= head.sig)
                data_next = CH_SPACE;
            else
                data_next = CH_ZERO + {4'd0, head.digits[dpos]};
        end
        else
        begin
            data_next = head.body.b[bidx[1:0]];
        end
    end

    assign pop = load && !empty && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            pos_reg      <= 4'd0;
        end
        else if (load)
        begin
            m_tvalid_reg <= !empty;
            if (!empty)
                pos_reg <= is_last ? 4'd0 : pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            m_tdata_reg <= data_next;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/core/text_escape_line_numberer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_escape_line_numberer_unit: caret-notation escaper with line numbers
// Turns a byte stream into formatted text: optional right-justified BCD line
// numbers, blank-line squeezing, ^I / ^X / ^? / M- escapes and '$' ends.
//
// Usage:
//   Slave beat: s_tdata carries the raw byte, s_tuser marks end of stream
//   (the byte is then ignored and any open line is closed).
//   Master beat: m_tdata is one output byte, m_tlast flags the final byte
//   caused by one input beat. Inputs that print nothing yield no beat.
//   Configuration: write cfg_wdata to register cfg_addr while cfg_we is high;
//   write only while the block is idle.
// Timing:
//   The classifier takes one input beat per cycle while the command queue
//   has room. The serializer sends one output byte per cycle while m_tready
//   is high, so an input beat yields 1 to 15 output bytes (about one for plain
//   text, up to 15 for a numbered line start); the output port sets the rate.
//   An item's first byte passes through the queue and the output register.
// Reset: clears the line count to zero, starts a new line, clears the
//   configuration registers to zero and empties the queue.
// Stall: when m_tready is low the output beat holds, the queue fills, and
//   s_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module text_escape_line_numberer_unit
    import tel_pkg::*;
#(
    parameter int COUNT_DIGITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] in_byte
    input  logic                  s_tuser,   // [0] op: end of stream
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast
);

    cfg_t cfg_reg;
    cmd_t push_cmd, head;
    logic push, pop, full, empty;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_NUMBER_MODE: cfg_reg.number_mode <= cfg_wdata[1:0];
                REG_MARK_ENDS:   cfg_reg.mark_ends   <= cfg_wdata[0];
                REG_CARET_TABS:  cfg_reg.caret_tabs  <= cfg_wdata[0];
                REG_CARET_CTRL:  cfg_reg.caret_ctrl  <= cfg_wdata[0];
                REG_FOLD_BLANKS: cfg_reg.fold_blanks <= cfg_wdata[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Front: classify each beat and advance line state
    tel_front #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_byte  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    // Queue: decouple classification from serialization
    tel_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    // Back: serialize one byte per beat into the output register
    tel_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== verif/tb_text_escape_line_numberer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_escape_line_numberer_unit: self-checking bench for the text escaper
// Feeds raw bytes and end-of-stream marks, predicts every output byte with a
// behavioral model of line numbering, blank squeezing, caret / M- escapes and
// '$' ends, and checks each output beat in order. Directed cases come first,
// then random line traffic under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_text_escape_line_numberer_unit;
    import tel_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int COUNT_DIGITS  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 60;
    localparam int PHASE_COUNT   = 8;

    // Input beat kinds carried on s_tuser
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // Numbering modes not named in the package
    localparam logic [1:0] MODE_NONBLANK = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    // Register indexes with no register behind them
    localparam int REG_SPARE_LO = 5;
    localparam int REG_SPARE_HI = 7;

    localparam logic [7:0] CH_DEL = {1'b0, LOW_DEL};

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } text_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // [7:0] in_byte
    logic                  s_tuser;    // [0] op: end of stream
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;    // [7:0] out_byte
    logic                  m_tlast;

    // Model state: a mirror of the block's registers and line tracking
    cfg_t       model_cfg;
    logic       at_start;
    logic [1:0] blank_streak;
    logic [3:0] line_num [COUNT_DIGITS];   // BCD, least significant digit first

    logic [7:0] step_bytes [$];           // bytes caused by the current beat
    text_beat_t expected_text [$];        // output beats still owed by the DUT

    int mismatches    = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int ready_stall_pct = 0;

    text_escape_line_numberer_unit #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    // Abort a hung run; the limit sits far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("** text_escape_line_numberer_unit: FAILED **");
            $finish;
        end
    end

    // Receiver: stall at random per the current phase, change on falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void emit(input logic [7:0] b);
        step_bytes = {step_bytes, b};
    endfunction

    function automatic void emit_line_end();
        if (model_cfg.mark_ends)
            emit(CH_DOLLAR);
        emit(CH_LF);
    endfunction

    // Low seven bits in caret form: controls as ^X, DEL as ^?
    function automatic void emit_caret(input logic [6:0] low);
        if (low < CTRL_LIMIT)
        begin
            emit(CH_CARET);
            emit({1'b0, low} + CARET_OFFSET);
        end
        else if (low == LOW_DEL)
        begin
            emit(CH_CARET);
            emit(CH_QUEST);
        end
        else
            emit({1'b0, low});
    endfunction

    function automatic void emit_char(input logic [7:0] c);
        if (model_cfg.caret_tabs && c == CH_TAB)
        begin
            emit(CH_CARET);
            emit(CH_I);
        end
        else if (model_cfg.caret_ctrl)
        begin
            // Plain tab and newline pass; after M- any control is escaped
            if (c == CH_TAB || c == CH_LF)
                emit(c);
            else
            begin
                if (c[7])
                begin
                    emit(CH_M);
                    emit(CH_DASH);
                end
                emit_caret(c[6:0]);
            end
        end
        else
            emit(c);
    endfunction

    // Advance the BCD count (saturating at all nines), then print it
    // right-justified in at least six places followed by a space
    function automatic void emit_line_number();
        logic all_nines;
        int   sig;
        int   width;
        all_nines = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++)
            if (line_num[i] != 4'd9)
                all_nines = 1'b0;
        if (!all_nines)
        begin
            for (int i = 0; i < COUNT_DIGITS; i++)
            begin
                if (line_num[i] == 4'd9)
                    line_num[i] = 4'd0;
                else
                begin
                    line_num[i] = line_num[i] + 4'd1;
                    break;
                end
            end
        end
        sig = 1;
        for (int i = 0; i < COUNT_DIGITS; i++)
            if (line_num[i] != 4'd0)
                sig = i + 1;
        if (sig > SHOW_DIGITS)
            sig = SHOW_DIGITS;
        width = (sig > NUM_WIDTH) ? sig : NUM_WIDTH;
        for (int pos = width - 1; pos >= 0; pos--)
        begin
            if (pos < sig)
                emit(CH_ZERO + {4'd0, line_num[pos]});
            else
                emit(CH_SPACE);
        end
        emit(CH_SPACE);
    endfunction

    // Work out every output beat caused by one accepted input beat
    function automatic void predict_text(input logic op, input logic [7:0] c);
        logic squeeze;
        text_beat_t beat;
        squeeze = model_cfg.fold_blanks;
        step_bytes.delete();
        if (op == OP_EOS)
        begin
            // Close an open line; nothing to emit otherwise
            if (!at_start)
                emit_line_end();
            at_start     = 1'b1;
            blank_streak = 2'd0;
        end
        else if (at_start)
        begin
            if (c == CH_LF)
            begin
                if (squeeze)
                begin
                    if (blank_streak < 2'd2)
                        blank_streak = blank_streak + 2'd1;
                end
                else
                    blank_streak = 2'd0;
                // Repeat blank lines vanish entirely while squeezing
                if (!(squeeze && blank_streak > 2'd1))
                begin
                    if (model_cfg.number_mode == MODE_ALL)
                        emit_line_number();
                    emit_line_end();
                end
            end
            else
            begin
                blank_streak = 2'd0;
                if (model_cfg.number_mode != MODE_NONE)
                    emit_line_number();
                emit_char(c);
                at_start = 1'b0;
            end
        end
        else if (c == CH_LF)
        begin
            emit_line_end();
            at_start = 1'b1;
        end
        else
            emit_char(c);

        foreach (step_bytes[i])
        begin
            beat.out_byte = step_bytes[i];
            beat.last     = (i == step_bytes.size() - 1);
            expected_text = {expected_text, beat};
        end
    endfunction

    function automatic void model_register(input logic [CFG_ADDR_W-1:0] addr,
                                           input logic [CFG_DATA_W-1:0] val);
        case (addr)
            REG_NUMBER_MODE: model_cfg.number_mode = val;
            REG_MARK_ENDS:   model_cfg.mark_ends   = val[0];
            REG_CARET_TABS:  model_cfg.caret_tabs  = val[0];
            REG_CARET_CTRL:  model_cfg.caret_ctrl  = val[0];
            REG_FOLD_BLANKS: model_cfg.fold_blanks = val[0];
            default:         ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Output check: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        text_beat_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected output beat: out_byte %h last %b", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (m_tdata !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one input beat; returns on the falling edge after acceptance
    // with tvalid still high, so back-to-back beats stay back to back
    task automatic send_beat(input logic op, input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_text(op, data);
        @(negedge clk);
    endtask

    // Hold the input idle until every owed beat has arrived, then let
    // extra cycles pass for beats that print nothing
    task automatic wait_for_text(input int extra);
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_text.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        model_register(addr, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drain, then write every register
    task automatic program_config(input logic [1:0] mode, input logic [1:0] ends,
                                  input logic [1:0] tabs, input logic [1:0] np,
                                  input logic [1:0] squeeze);
        wait_for_text(SETTLE_CYCLES);
        write_reg(REG_NUMBER_MODE, mode);
        write_reg(REG_MARK_ENDS, ends);
        write_reg(REG_CARET_TABS, tabs);
        write_reg(REG_CARET_CTRL, np);
        write_reg(REG_FOLD_BLANKS, squeeze);
    endtask

    // Line content biased toward the bytes that get escaped
    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 9))
            0:       return CH_TAB;
            1:       return 8'($urandom_range(0, 31));
            2:       return CH_DEL;
            3, 4:    return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_plain_text();
        program_config(MODE_NONE, 2'd0, 2'd0, 2'd0, 2'd0);
        send_beat(OP_DATA, 8'h41);
        send_beat(OP_DATA, CH_LF);
        send_beat(OP_EOS, 8'hFF);          // no open line: prints nothing
    endtask

    task automatic test_line_ends();
        program_config(MODE_NONE, 2'd1, 2'd0, 2'd0, 2'd0);
        send_beat(OP_DATA, 8'h78);
        send_beat(OP_EOS, 8'h00);          // closes the open line with $
    endtask

    task automatic test_numbering();
        program_config(MODE_ALL, 2'd0, 2'd0, 2'd0, 2'd0);
        send_beat(OP_DATA, CH_LF);         // blank line, still numbered
        send_beat(OP_DATA, 8'h62);
        send_beat(OP_DATA, CH_LF);
        // unused mode code acts like non-blank numbering
        program_config(MODE_SPARE, 2'd0, 2'd0, 2'd0, 2'd0);
        send_beat(OP_DATA, CH_LF);
        send_beat(OP_DATA, 8'h63);
        send_beat(OP_EOS, 8'h5A);
    endtask

    task automatic test_escapes();
        program_config(MODE_NONE, 2'd0, 2'd1, 2'd1, 2'd0);
        send_beat(OP_DATA, CH_TAB);
        send_beat(OP_DATA, 8'h00);
        send_beat(OP_DATA, 8'h1F);
        send_beat(OP_DATA, CH_DEL);
        send_beat(OP_DATA, 8'h80);
        send_beat(OP_DATA, 8'h8A);         // M- form escapes the newline part
        send_beat(OP_DATA, 8'hFF);
        send_beat(OP_DATA, CH_LF);
        // tab passes untouched with only nonprinting display on
        program_config(MODE_NONE, 2'd0, 2'd0, 2'd1, 2'd0);
        send_beat(OP_DATA, CH_TAB);
        send_beat(OP_DATA, CH_LF);
    endtask

    task automatic test_squeeze();
        program_config(MODE_NONBLANK, 2'd0, 2'd0, 2'd0, 2'd1);
        send_beat(OP_DATA, CH_LF);
        send_beat(OP_DATA, CH_LF);         // squeezed away
        send_beat(OP_DATA, CH_LF);
        send_beat(OP_EOS, 8'h00);          // new stream clears the blank run
        send_beat(OP_DATA, CH_LF);
    endtask

    task automatic test_spare_registers();
        program_config(MODE_NONE, 2'd1, 2'd0, 2'd0, 2'd0);
        for (int a = REG_SPARE_LO; a <= REG_SPARE_HI; a++)
            write_reg(a[CFG_ADDR_W-1:0], 2'b11);
        // only bit 0 counts for a one-bit register: this clears the end mark
        write_reg(REG_MARK_ENDS, 2'b10);
        send_beat(OP_DATA, 8'h7A);
        send_beat(OP_DATA, CH_LF);
    endtask

    // One phase of random lines under a given idle / stall mix
    task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                     input logic [1:0] mode, input logic [1:0] ends,
                                     input logic [1:0] tabs, input logic [1:0] np,
                                     input logic [1:0] squeeze);
        int  sent;
        int  pick;
        int  len;
        logic paused;
        program_config(mode, ends, tabs, np, squeeze);
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                // Well-formed line: random body, often empty, then an end
                len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                repeat (len)
                begin
                    send_beat(OP_DATA, pick_text_byte());
                    sent++;
                end
                if ($urandom_range(0, 7) == 0)
                    send_beat(OP_EOS, 8'($urandom));
                else
                    send_beat(OP_DATA, CH_LF);
            end
            else if (pick < 92)
                send_beat(OP_DATA, 8'($urandom));
            else
                send_beat(OP_EOS, 8'($urandom));
            sent++;
            // Midway, hold the sender until the output has caught up
            if (!paused && sent >= PHASE_ITEMS / 2)
            begin
                wait_for_text(0);
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_random_traffic();
        int idle_pct;
        int stall_pct;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 53; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            if (p == 0)
                run_traffic_phase(idle_pct, stall_pct, MODE_SPARE,
                                  2'b11, 2'b11, 2'b11, 2'b11);
            else if (p == 1)
                run_traffic_phase(idle_pct, stall_pct, MODE_NONE,
                                  2'b00, 2'b00, 2'b00, 2'b00);
            else if (p == 2)
                run_traffic_phase(idle_pct, stall_pct, MODE_NONBLANK,
                                  2'($urandom), 2'($urandom), 2'($urandom), 2'b01);
            else
                run_traffic_phase(idle_pct, stall_pct, 2'($urandom),
                                  2'($urandom), 2'($urandom), 2'($urandom),
                                  2'($urandom));
        end
        send_idle_pct   = 0;
        ready_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Hold every input at a known value and mirror the reset state
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_DATA;
        m_tready  = 1'b0;
        model_cfg    = '0;
        at_start     = 1'b1;
        blank_streak = 2'd0;
        foreach (line_num[i])
            line_num[i] = 4'd0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_plain_text();
        test_line_ends();
        test_numbering();
        test_escapes();
        test_squeeze();
        test_spare_registers();
        test_random_traffic();

        wait_for_text(SETTLE_CYCLES);
        if (mismatches == 0 && expected_text.size() == 0)
            $display("** text_escape_line_numberer_unit: PASSED **");
        else
            $display("** text_escape_line_numberer_unit: FAILED **");
        $finish;
    end

endmodule
